### rtl/chunked_body_deframer_macros.svh
// Assertion macros used by the chunked body deframer RTL.
`ifndef CHUNKED_BODY_DEFRAMER_MACROS_SVH
`define CHUNKED_BODY_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chunked_body_deframer: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chunked_body_deframer: next-cycle check failed");

`endif

### rtl/cbd_pkg.sv
// Types and constants shared by the chunked body deframer modules.
`default_nettype none
package cbd_pkg;

    localparam int unsigned CHUNK_W = 41;
    localparam int unsigned LINE_W  = 17;

    localparam logic [2:0] PH_SIZE    = 3'd0;
    localparam logic [2:0] PH_DATA    = 3'd1;
    localparam logic [2:0] PH_TERM    = 3'd2;
    localparam logic [2:0] PH_TRAILER = 3'd3;
    localparam logic [2:0] PH_IDLE    = 3'd4;

    localparam logic [1:0] PART_SIZE    = 2'd0;
    localparam logic [1:0] PART_DATA    = 2'd1;
    localparam logic [1:0] PART_TERM    = 2'd2;
    localparam logic [1:0] PART_TRAILER = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_LINE_LONG = 3'd3;
    localparam logic [2:0] ST_OUTSIDE   = 3'd4;

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    localparam logic [0:0] REG_MAX_CHUNK = 1'b0;
    localparam logic [0:0] REG_MAX_LINE  = 1'b1;

    localparam logic [CHUNK_W-1:0] MAX_CHUNK_RESET = 41'h100_0000_0000;
    localparam logic [LINE_W-1:0]  MAX_LINE_RESET  = 17'h1_0000;

    typedef struct packed {
        logic [2:0]         phase;
        logic [CHUNK_W-1:0] size_accum;
        logic               size_overflow;
        logic               digit_seen;
        logic               digits_stopped;
        logic [CHUNK_W-1:0] data_left;
        logic [LINE_W-1:0]  line_length;
        logic               cr_held;
        logic               terminator_count;
    } state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] part;
        logic [2:0] status;
        logic       body_end;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] nres;
        result_t    res0;
        result_t    res1;
    } step_out_t;

endpackage
`default_nettype wire

### rtl/cbd_step.sv
// Next-state and result logic for one byte of the chunked body.
`default_nettype none
module cbd_step (
    input  cbd_pkg::state_t                 state,
    input  logic [7:0]                      in_byte,
    input  logic                            body_start,
    input  logic [cbd_pkg::CHUNK_W-1:0]     max_chunk_size,
    input  logic [cbd_pkg::LINE_W-1:0]      max_line_len,
    output cbd_pkg::state_t                 state_next,
    output cbd_pkg::step_out_t              step_out
);
    import cbd_pkg::*;

    typedef struct packed {
        state_t  st;
        result_t res;
        logic    ok;
    } content_t;

    function automatic result_t mk(logic [7:0] b, logic [1:0] pt, logic [2:0] stat,
                                   logic fin);
        result_t r;
        r.out_byte = b;
        r.part     = pt;
        r.status   = stat;
        r.body_end = fin;
        r.last     = 1'b0;
        return r;
    endfunction

    // Bit 4 flags a hex digit, bits 3:0 give its value.
    function automatic logic [4:0] hex_decode(logic [7:0] c);
        logic [4:0] h;
        h = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            h = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            h = {1'b1, 4'(c - 8'h37)};
        end
        return h;
    endfunction

    // One content byte of a size or trailer line.
    function automatic content_t content(state_t st, logic [7:0] b, logic [1:0] pt,
                                         logic [CHUNK_W-1:0] mcs, logic [LINE_W-1:0] mll);
        content_t c;
        logic [4:0] h;
        logic [CHUNK_W+3:0] v;
        c.st  = st;
        c.res = mk(b, pt, ST_OK, 1'b0);
        c.ok  = 1'b1;
        h = hex_decode(b);
        v = {st.size_accum, h[3:0]};
        if (st.line_length >= mll) begin
            c.res        = mk(8'd0, pt, ST_LINE_LONG, 1'b0);
            c.st.phase   = PH_IDLE;
            c.st.cr_held = 1'b0;
            c.ok         = 1'b0;
        end
        else begin
            c.st.line_length = st.line_length + 1'b1;
            if (st.phase == PH_SIZE && !st.digits_stopped) begin
                if (!h[4]) begin
                    c.st.digits_stopped = 1'b1;
                end
                else begin
                    c.st.digit_seen = 1'b1;
                    if (v > {4'd0, mcs}) begin
                        c.st.size_overflow = 1'b1;
                    end
                    else begin
                        c.st.size_accum = v[CHUNK_W-1:0];
                    end
                end
            end
        end
        return c;
    endfunction

    always_comb
    begin
        state_t    s;
        state_t    n;
        content_t  ca;
        content_t  cb;
        step_out_t o;
        logic [1:0] k;
        logic [1:0] pt;
        logic       go;

        s = state;
        if (body_start) begin
            s = '0;
            s.phase = PH_SIZE;
        end
        n  = s;
        o  = '0;
        k  = 2'd0;
        ca = '0;
        cb = '0;
        pt = PART_SIZE;
        go = 1'b1;

        case (s.phase)
            PH_SIZE, PH_TRAILER:
            begin
                pt = (s.phase == PH_SIZE) ? PART_SIZE : PART_TRAILER;
                if (in_byte == BYTE_LF) begin
                    n.cr_held = 1'b0;
                    if (s.phase == PH_SIZE && (!s.digit_seen || s.size_overflow)) begin
                        o.res0 = mk(8'd0, pt, s.digit_seen ? ST_TOO_LARGE : ST_BAD_SIZE,
                                    1'b0);
                        n.phase = PH_IDLE;
                        k = 2'd1;
                    end
                    else begin
                        o.res0 = mk(BYTE_CR, pt, ST_OK, 1'b0);
                        if (s.phase == PH_SIZE) begin
                            o.res1 = mk(BYTE_LF, pt, ST_OK, 1'b0);
                            if (s.size_accum == '0) begin
                                n.phase = PH_TRAILER;
                            end
                            else begin
                                n.data_left = s.size_accum;
                                n.phase     = PH_DATA;
                            end
                            n.size_accum     = '0;
                            n.size_overflow  = 1'b0;
                            n.digit_seen     = 1'b0;
                            n.digits_stopped = 1'b0;
                        end
                        else begin
                            o.res1 = mk(BYTE_LF, pt, ST_OK, s.line_length == '0);
                            if (s.line_length == '0) begin
                                n.phase = PH_IDLE;
                            end
                        end
                        n.line_length = '0;
                        k = 2'd2;
                    end
                end
                else begin
                    // A held CR turned out to be line content, so it goes out first.
                    if (s.cr_held) begin
                        n.cr_held = 1'b0;
                        ca = content(n, BYTE_CR, pt, max_chunk_size, max_line_len);
                        n = ca.st;
                        o.res0 = ca.res;
                        k = 2'd1;
                        go = ca.ok;
                    end
                    if (go) begin
                        if (in_byte == BYTE_CR) begin
                            n.cr_held = 1'b1;
                        end
                        else begin
                            cb = content(n, in_byte, pt, max_chunk_size, max_line_len);
                            n = cb.st;
                            if (k == 2'd0) begin
                                o.res0 = cb.res;
                            end
                            else begin
                                o.res1 = cb.res;
                            end
                            k = k + 2'd1;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                o.res0 = mk(in_byte, PART_DATA, ST_OK, 1'b0);
                n.data_left = s.data_left - 1'b1;
                if (n.data_left == '0) begin
                    n.phase = PH_TERM;
                    n.terminator_count = 1'b0;
                end
                k = 2'd1;
            end
            PH_TERM:
            begin
                o.res0 = mk(in_byte, PART_TERM, ST_OK, 1'b0);
                if (s.terminator_count) begin
                    n.terminator_count = 1'b0;
                    n.phase            = PH_SIZE;
                    n.line_length      = '0;
                    n.cr_held          = 1'b0;
                end
                else begin
                    n.terminator_count = 1'b1;
                end
                k = 2'd1;
            end
            default:
            begin
                o.res0 = mk(8'd0, PART_SIZE, ST_OUTSIDE, 1'b0);
                k = 2'd1;
            end
        endcase

        if (k == 2'd1) begin
            o.res0.last = 1'b1;
        end
        else if (k == 2'd2) begin
            o.res1.last = 1'b1;
        end
        o.nres = k;

        state_next = n;
        step_out   = o;
    end

endmodule
`default_nettype wire

### rtl/cbd_obuf.sv
// Three-entry result queue that takes up to two results per transfer.
`default_nettype none
module cbd_obuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_en,
    input  cbd_pkg::step_out_t  push,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output cbd_pkg::result_t    head
);
    import cbd_pkg::*;

    localparam int unsigned DEPTH = 3;

    result_t    ent_reg  [DEPTH];
    result_t    ent_next [DEPTH];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;
    logic [1:0] cnt_after;
    logic [1:0] n_push;

    assign pop       = (count_reg != 2'd0) && !out_stall;
    assign cnt_after = count_reg - {1'b0, pop};
    assign n_push    = push_en ? push.nres : 2'd0;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++) begin
            if (pop && i < DEPTH - 1) begin
                ent_next[i] = ent_reg[i + 1];
            end
            else begin
                ent_next[i] = ent_reg[i];
            end
            if (n_push != 2'd0 && {1'b0, cnt_after} == 3'(i)) begin
                ent_next[i] = push.res0;
            end
            if (n_push == 2'd2 && ({1'b0, cnt_after} + 3'd1) == 3'(i)) begin
                ent_next[i] = push.res1;
            end
        end
        count_next = cnt_after + n_push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 2'd0;
        end
        else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++) begin
            ent_reg[i] <= ent_next[i];
        end
    end

    // Room for two results is always kept before a transfer is taken.
    assign full      = count_reg >= 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign head      = ent_reg[0];

endmodule
`default_nettype wire

### rtl/chunked_body_deframer.sv
// Results are registered in the result queue before they reach the output.
// Throughput: one byte per cycle while the output does not stall; a byte that yields two results
// (a line end, or a released CR) holds off the next input transfer until the queue pops one.
// The result queue holds three entries; input stalls while two or more wait.
// Reset clears the framing state and queue and loads the default limits.
`default_nettype none
`include "chunked_body_deframer_macros.svh"
module chunked_body_deframer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_index,
    input  logic [cbd_pkg::CHUNK_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      in_byte,
    input  logic                            body_start,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      out_byte,
    output logic [1:0]                      part,
    output logic [2:0]                      status,
    output logic                            body_end,
    output logic                            last
);
    import cbd_pkg::*;

    logic [CHUNK_W-1:0] max_chunk_size_reg;
    logic [LINE_W-1:0]  max_line_len_reg;
    state_t             state_reg;
    state_t             state_next;
    step_out_t          step_out;
    result_t            head;
    logic               full;
    logic               in_xfer;

    assign in_stall = full;
    assign in_xfer  = in_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_chunk_size_reg <= MAX_CHUNK_RESET;
            max_line_len_reg   <= MAX_LINE_RESET;
        end
        else if (cfg_we) begin
            if (cfg_index == REG_MAX_CHUNK) begin
                max_chunk_size_reg <= cfg_data;
            end
            else begin
                max_line_len_reg <= cfg_data[LINE_W-1:0];
            end
        end
    end

    cbd_step u_step (
        .state          (state_reg),
        .in_byte        (in_byte),
        .body_start     (body_start),
        .max_chunk_size (max_chunk_size_reg),
        .max_line_len   (max_line_len_reg),
        .state_next     (state_next),
        .step_out       (step_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            // Every framing field resets to zero, and zero is also the size line phase.
            state_reg <= '0;
        end
        else if (in_xfer) begin
            state_reg <= state_next;
        end
    end

    cbd_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (in_xfer),
        .push      (step_out),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign out_byte = head.out_byte;
    assign part     = head.part;
    assign status   = head.status;
    assign body_end = head.body_end;
    assign last     = head.last;

    `CBD_ASSERT_IMP(a_err_zero_byte, clk, rst_n, out_valid && status != ST_OK, out_byte == 8'd0)
    `CBD_ASSERT_IMP(a_end_on_trailer_lf, clk, rst_n, out_valid && body_end,
        last && status == ST_OK && part == PART_TRAILER && out_byte == BYTE_LF)
    `CBD_ASSERT_NXT(a_start_phase, clk, rst_n, in_xfer && body_start,
        state_reg.phase == PH_SIZE || state_reg.phase == PH_IDLE)

endmodule
`default_nettype wire
